// ===== src/afe_pkg.sv =====
// Shared types and constants of the API frame encoder.
package afe_pkg;

  localparam logic [7:0]  TX_REQUEST_TYPE = 8'h10;
  localparam logic [7:0]  RESERVED_HI     = 8'hFF;
  localparam logic [7:0]  RESERVED_LO     = 8'hFE;
  localparam logic [15:0] AT_LEN_BASE     = 16'd4;
  localparam logic [15:0] TX_LEN_BASE     = 16'd14;
  localparam logic [4:0]  HDR_LAST_AT     = 5'd6;
  localparam logic [4:0]  HDR_LAST_TX     = 5'd16;
  localparam logic [4:0]  HDR_IDX_LEN_LO  = 5'd2;
  localparam logic [4:0]  HDR_IDX_TYPE    = 5'd3;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  localparam logic [1:0]  CFG_DELIMITER   = 2'd0;
  localparam logic [1:0]  CFG_CSUM_INIT   = 2'd1;
  localparam logic [1:0]  CFG_CAPACITY    = 2'd2;

  localparam logic [0:0]  OP_AT           = 1'b0;
  localparam logic [0:0]  OP_TX           = 1'b1;

  typedef enum logic [1:0] {
    PH_START,
    PH_HDR,
    PH_DATA,
    PH_CSUM
  } phase_e;

  // One queued item, already classified by the front end.
  typedef struct packed {
    logic        is_tx;
    logic        hdr;
    logic        has_data;
    logic        last;
    logic [15:0] len;
    logic [7:0]  frame_tag;
    logic [7:0]  api_type;
    logic [15:0] at_command;
    logic [63:0] dst_address;
    logic [7:0]  hops;
    logic [7:0]  tx_options;
    logic [7:0]  data_byte;
  } entry_t;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic [7:0]  checksum_init;
    logic [15:0] buffer_capacity;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/afe_front.sv =====
// Front end: classifies incoming items and drops those that emit nothing.
module afe_front (
  input  logic               opcode_i,
  input  logic [7:0]         frame_tag_i,
  input  logic [7:0]         api_type_i,
  input  logic [15:0]        at_command_i,
  input  logic [63:0]        dst_address_i,
  input  logic [7:0]         hops_i,
  input  logic [7:0]         tx_options_i,
  input  logic [14:0]        body_len_i,
  input  logic [7:0]         data_byte_i,
  input  logic               has_data_i,
  input  logic               first_i,
  input  logic               last_i,
  output afe_pkg::entry_t    entry_o,
  output logic               keep_o
);
  import afe_pkg::*;

  logic is_tx;

  assign is_tx = (opcode_i == OP_TX);

  always_comb begin
    entry_o.is_tx       = is_tx;
    entry_o.hdr         = first_i;
    entry_o.has_data    = has_data_i;
    entry_o.last        = last_i;
    entry_o.len         = (is_tx ? TX_LEN_BASE : AT_LEN_BASE) + {1'b0, body_len_i};
    entry_o.frame_tag   = frame_tag_i;
    entry_o.api_type    = api_type_i;
    entry_o.at_command  = at_command_i;
    entry_o.dst_address = dst_address_i;
    entry_o.hops        = hops_i;
    entry_o.tx_options  = tx_options_i;
    entry_o.data_byte   = data_byte_i;
  end

  // An item with no header, no payload byte and no checksum leaves no trace.
  assign keep_o = first_i | has_data_i | last_i;

endmodule

// ===== src/afe_queue.sv =====
// Small item queue between the front end and the byte sequencer.
module afe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  afe_pkg::entry_t      push_data_i,
  input  logic                 pop_i,
  output afe_pkg::entry_t      head_o,
  output afe_pkg::q_status_t   status_o
);
  import afe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          entries_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/afe_back.sv =====
// Back end: expands the head item into frame bytes, one per cycle while the output is not stalled.
module afe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afe_pkg::cfg_t      cfg_i,
  input  afe_pkg::entry_t    head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               end_of_frame_o,
  output logic               overflow_o
);
  import afe_pkg::*;

  phase_e        phase_q, phase_d;
  phase_e        ph;
  logic [4:0]    idx_q, idx_d;
  logic [4:0]    idx;
  logic [7:0]    csum_q, csum_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [15:0]   cnt_eff;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          eof_q, ov_q;
  logic          advance;
  logic          hdr_end;
  logic          item_done;
  logic          summed;
  logic [7:0]    cur_byte;
  logic [7:0]    hdr_byte;

  // Phase of the head item; a fresh item starts where its flags say.
  always_comb begin
    if (phase_q == PH_START) begin
      idx = '0;
      if (head_i.hdr) begin
        ph = PH_HDR;
      end else if (head_i.has_data) begin
        ph = PH_DATA;
      end else begin
        ph = PH_CSUM;
      end
    end else begin
      idx = idx_q;
      ph  = phase_q;
    end
  end

  always_comb begin
    unique case (idx)
      5'd0:    hdr_byte = cfg_i.delimiter;
      5'd1:    hdr_byte = head_i.len[15:8];
      5'd2:    hdr_byte = head_i.len[7:0];
      5'd3:    hdr_byte = head_i.is_tx ? TX_REQUEST_TYPE : head_i.api_type;
      5'd4:    hdr_byte = head_i.frame_tag;
      5'd5:    hdr_byte = head_i.is_tx ? head_i.dst_address[63:56] : head_i.at_command[15:8];
      5'd6:    hdr_byte = head_i.is_tx ? head_i.dst_address[55:48] : head_i.at_command[7:0];
      5'd7:    hdr_byte = head_i.dst_address[47:40];
      5'd8:    hdr_byte = head_i.dst_address[39:32];
      5'd9:    hdr_byte = head_i.dst_address[31:24];
      5'd10:   hdr_byte = head_i.dst_address[23:16];
      5'd11:   hdr_byte = head_i.dst_address[15:8];
      5'd12:   hdr_byte = head_i.dst_address[7:0];
      5'd13:   hdr_byte = RESERVED_HI;
      5'd14:   hdr_byte = RESERVED_LO;
      5'd15:   hdr_byte = head_i.hops;
      5'd16:   hdr_byte = head_i.tx_options;
      default: hdr_byte = 8'h00;
    endcase
  end

  // Output-side decode of the current byte.
  always_comb begin
    advance = head_valid_i & (~out_valid_q | ~out_stall_i);
    hdr_end = (idx == (head_i.is_tx ? HDR_LAST_TX : HDR_LAST_AT));
    unique case (ph)
      PH_HDR: begin
        cur_byte  = hdr_byte;
        summed    = (idx >= HDR_IDX_TYPE);
        item_done = hdr_end & ~head_i.has_data & ~head_i.last;
      end
      PH_DATA: begin
        cur_byte  = head_i.data_byte;
        summed    = 1'b1;
        item_done = ~head_i.last;
      end
      PH_CSUM: begin
        cur_byte  = csum_q;
        summed    = 1'b1;
        item_done = 1'b1;
      end
      default: begin
        cur_byte  = 8'h00;
        summed    = 1'b0;
        item_done = 1'b0;
      end
    endcase
    // The delimiter of a new frame restarts the byte count.
    cnt_eff = (ph == PH_HDR && idx == '0) ? '0 : cnt_q;
    pop_o   = advance & item_done;
  end

  // Next state of the sequencer and of the running frame state.
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    csum_d      = csum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
      cnt_d       = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
      if (ph == PH_HDR && idx == HDR_IDX_LEN_LO) begin
        csum_d = cfg_i.checksum_init;
      end else if (summed) begin
        csum_d = csum_q - cur_byte;
      end
      if (item_done) begin
        phase_d = PH_START;
        idx_d   = '0;
      end else if (ph == PH_HDR && !hdr_end) begin
        phase_d = PH_HDR;
        idx_d   = idx + 1'b1;
      end else if (ph == PH_HDR) begin
        phase_d = head_i.has_data ? PH_DATA : PH_CSUM;
        idx_d   = '0;
      end else begin
        phase_d = PH_CSUM;
        idx_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      idx_q       <= '0;
      csum_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      csum_q      <= csum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      eof_q      <= (ph == PH_CSUM);
      ov_q       <= (cnt_eff >= cfg_i.buffer_capacity);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign end_of_frame_o = eof_q;
  assign overflow_o     = ov_q;

endmodule

// ===== src/api_frame_encoder_unit.sv =====
// Top level of the API frame encoder: configuration, front end, queue, byte sequencer.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    frame item fields
//   out      source     out_valid_o / out_stall_i  out_byte, end_of_frame, overflow
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// The output register moves one byte per cycle while out_stall_i is low and sets the rate.
// A payload-only item emits one byte, a last item adds one byte for the checksum,
// and a first item adds 7 header bytes for an AT frame or 17 for a transmit request.
// Items wait in a QUEUE_DEPTH-entry queue and in_stall_o is high only while it is full;
// items with nothing to emit are dropped at the front and never occupy the queue.
// Reset (asynchronous, active low) restores the register defaults and clears the state.
module api_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  frame_tag_i,
  input  logic [7:0]  api_type_i,
  input  logic [15:0] at_command_i,
  input  logic [63:0] dst_address_i,
  input  logic [7:0]  hops_i,
  input  logic [7:0]  tx_options_i,
  input  logic [14:0] body_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_data_i,
  input  logic        first_i,
  input  logic        last_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_frame_o,
  output logic        overflow_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import afe_pkg::*;

  cfg_t       cfg_q;
  entry_t     front_entry;
  entry_t     head;
  logic       keep;
  logic       push;
  logic       pop;
  q_status_t  q_status;

  // Registers are always writable; writes to an unused index are ignored.
  assign cfg_ready_o = 1'b1;

  // Defaults: delimiter 0x7E, checksum init 0xFF, capacity 0xFFFF.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter       <= 8'd126;
      cfg_q.checksum_init   <= 8'd255;
      cfg_q.buffer_capacity <= 16'd65535;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DELIMITER: cfg_q.delimiter       <= cfg_data_i[7:0];
        CFG_CSUM_INIT: cfg_q.checksum_init   <= cfg_data_i[7:0];
        CFG_CAPACITY:  cfg_q.buffer_capacity <= cfg_data_i;
        default: ;
      endcase
    end
  end

  afe_front u_front (
    .opcode_i      (opcode_i),
    .frame_tag_i   (frame_tag_i),
    .api_type_i    (api_type_i),
    .at_command_i  (at_command_i),
    .dst_address_i (dst_address_i),
    .hops_i        (hops_i),
    .tx_options_i  (tx_options_i),
    .body_len_i    (body_len_i),
    .data_byte_i   (data_byte_i),
    .has_data_i    (has_data_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .entry_o       (front_entry),
    .keep_o        (keep)
  );

  // The stall depends only on the registered queue fill, never on in_valid_i.
  assign in_stall_o = q_status.full;
  assign push       = in_valid_i & ~in_stall_o & keep;

  afe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  afe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .head_valid_i   (~q_status.empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .overflow_o     (overflow_o)
  );

  // The queue cannot report full and empty together.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // The sequencer only retires an item that is actually queued.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("item retired from an empty queue");

  // A byte appears on the output only after the sequencer had a queued item.
  a_out_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_status.empty))
    else $error("output byte without a queued item");

endmodule
